// ===== design/fpns_pkg.sv =====
// ----------------------------------------------------------------------------
// fpns_pkg: shared types and constants for the Newton square root
// Holds the fixed operand, root and guess widths and the status record
// that the serial units report to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpns_pkg;

    localparam int OPERAND_W = 32;
    localparam int ROOT_W    = 24;
    localparam int GUESS_W   = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// ===== design/fpns_isqrt.sv =====
// ----------------------------------------------------------------------------
// fpns_isqrt: serial integer square root
// Digit-by-digit restoring square root that takes two bits of the value and
// yields one bit of the root per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpns_isqrt
    import fpns_pkg::*;
#(
    parameter int IN_W = 15
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [IN_W-1:0]           value,
    output unit_stat_t                     stat,
    output logic      [(IN_W+1)/2-1:0]     root
);

    localparam int PAIRS = (IN_W + 1) / 2;
    localparam int SW    = 2 * PAIRS;
    localparam int REM_W = PAIRS + 3;
    localparam int CW    = $clog2(PAIRS + 1);

    logic [SW-1:0]    val_reg;
    logic [REM_W-1:0] rem_reg;
    logic [PAIRS-1:0] root_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[SW-1:SW-2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(PAIRS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= SW'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[SW-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[PAIRS-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

// ===== design/fpns_div.sv =====
// ----------------------------------------------------------------------------
// fpns_div: serial restoring divider
// Shifts the dividend through the partial remainder one bit per cycle and
// shifts the quotient bits into the freed low end of the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpns_div
    import fpns_pkg::*;
#(
    parameter int N_W = 47,
    parameter int D_W = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [N_W-1:0]   dividend,
    input  wire logic [D_W-1:0]   divisor,
    output unit_stat_t            stat,
    output logic      [N_W-1:0]   quotient
);

    localparam int CW = $clog2(N_W + 1);

    logic [N_W-1:0] num_reg;
    logic [D_W:0]   rem_reg;
    logic [D_W-1:0] den_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [D_W:0]   rem_sh;
    logic           take;

    assign rem_sh = {rem_reg[D_W-1:0], num_reg[N_W-1]};
    assign take   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? D_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[N_W-2:0], take};
            rem_reg <= take ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

`default_nettype wire

// ===== design/fixed_point_newton_sqrt.sv =====
// ----------------------------------------------------------------------------
// fixed_point_newton_sqrt: fixed-point square root by Newton iteration
// A serial integer root of the integer part seeds the guess, and a serial
// divider runs the Newton steps one after another.
// ----------------------------------------------------------------------------
//
// Channel   Ports                      Direction  Handshake
// input     start, busy, operand[31:0] in         taken when start and not busy
// result    done, root[23:0]           out        valid for the one cycle of done
//
// A positive item first runs the serial seed root, then NEWTON_STEPS
// divisions one after another; the serial divider gives one quotient bit
// per cycle. A zero or negative item gives its result on the next cycle
// with busy staying low. Reset is asynchronous and clears the sequencer;
// busy stays high while an item is at work, and the receiver cannot stall
// the result.
//
`default_nettype none

module fixed_point_newton_sqrt
    import fpns_pkg::*;
#(
    parameter int NEWTON_STEPS  = 5,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [OPERAND_W-1:0]   operand,
    output logic                        busy,
    output logic                        done,
    output logic      [ROOT_W-1:0]      root
);

    localparam int X_W    = OPERAND_W - 1;
    localparam int INT_W  = X_W - FRACTION_BITS;
    localparam int SQ_W   = (INT_W + 1) / 2;
    localparam int N_W    = X_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(NEWTON_STEPS + 1);
    localparam logic [GUESS_W-1:0] ONE = GUESS_W'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP
    } state_t;

    state_t              state_reg;
    logic [X_W-1:0]      x_reg;
    logic [GUESS_W-1:0]  y_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                sq_start_reg;
    logic                dv_start_reg;
    logic                done_reg;
    logic [ROOT_W-1:0]   root_reg;

    unit_stat_t          sq_stat;
    unit_stat_t          dv_stat;
    logic [SQ_W-1:0]     sq_root;
    logic [N_W-1:0]      dv_quot;

    logic                non_pos;
    logic [GUESS_W-1:0]  y_seed;
    logic [GUESS_W:0]    y_sum;
    logic [GUESS_W-1:0]  y_next;

    assign non_pos = operand[OPERAND_W-1] || (operand == '0);
    assign y_seed  = (sq_root == '0) ? ONE
                                     : GUESS_W'({sq_root, {FRACTION_BITS{1'b0}}});
    assign y_sum   = {1'b0, y_reg} + {1'b0, dv_quot[GUESS_W-1:0]};
    assign y_next  = y_sum[GUESS_W:1];

    fpns_isqrt #(
        .IN_W (INT_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .value (x_reg[X_W-1:FRACTION_BITS]),
        .stat  (sq_stat),
        .root  (sq_root)
    );

    fpns_div #(
        .N_W (N_W),
        .D_W (GUESS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start_reg),
        .dividend ({x_reg, {FRACTION_BITS{1'b0}}}),
        .divisor  (y_reg),
        .stat     (dv_stat),
        .quotient (dv_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            root_reg     <= '0;
        end
        else
        begin
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            done_reg     <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (non_pos)
                        begin
                            root_reg <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            x_reg        <= operand[X_W-1:0];
                            sq_start_reg <= 1'b1;
                            state_reg    <= ST_SEED;
                        end
                    end
                end
                ST_SEED:
                begin
                    if (sq_stat.done)
                    begin
                        y_reg        <= y_seed;
                        step_reg     <= '0;
                        dv_start_reg <= 1'b1;
                        state_reg    <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (dv_stat.done)
                    begin
                        y_reg <= y_next;
                        if (step_reg == STEP_W'(NEWTON_STEPS - 1))
                        begin
                            root_reg  <= y_next[ROOT_W-1:0];
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            step_reg     <= step_reg + 1'b1;
                            dv_start_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign root = root_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobe while an item is still at work.");

    a_non_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && non_pos) |=> (done && (root == '0)))
        else $error("Non-positive item did not give a zero root on the next cycle.");

    a_pos_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !non_pos) |=> (busy && !done))
        else $error("Positive item did not start the sequencer.");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_stat.busy && dv_stat.busy))
        else $error("Root unit and divider are both running.");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the fixed-point Newton square root
// Drives signed Q16.16 operands through the start/busy handshake and checks
// each strobed root against a predictor that repeats the seed search and the
// Newton steps in 64-bit arithmetic. A directed part covers the extremes and
// the special cases, then random items with random gaps cover the rest.
// ----------------------------------------------------------------------------

module tb_top;

    import fpns_pkg::*;

    localparam int SQRT_STEPS  = 5;
    localparam int Q_FRAC_BITS = 16;
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        logic [OPERAND_W-1:0] operand;
        logic [ROOT_W-1:0]    root;
    } root_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [OPERAND_W-1:0] operand;
    logic                 busy;
    logic                 done;
    logic [ROOT_W-1:0]    root;

    root_item_t pending_roots[$];
    int         items_sent;
    int         positive_items;
    int         roots_checked;
    int         fail_count;
    bit         idle_enabled;

    fixed_point_newton_sqrt #(
        .NEWTON_STEPS  (SQRT_STEPS),
        .FRACTION_BITS (Q_FRAC_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (operand),
        .busy    (busy),
        .done    (done),
        .root    (root)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ROOT_W-1:0] sqrt_q16(input logic [OPERAND_W-1:0] value);
        logic [63:0] x;
        logic [63:0] int_part;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] guess;
        logic [63:0] quot;
        logic [63:0] divisor;
        if (value[OPERAND_W-1] || value == '0)
        begin
            return '0;
        end
        x        = {32'd0, value};
        int_part = x >> Q_FRAC_BITS;
        lo       = 64'd0;
        hi       = 64'd65535;
        if (hi > int_part)
        begin
            hi = int_part + 64'd1;
        end
        while (lo < hi)
        begin
            mid = (lo + hi + 64'd1) >> 1;
            if (mid * mid <= int_part)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 64'd1;
            end
        end
        guess = lo << Q_FRAC_BITS;
        if (guess < (64'd1 << Q_FRAC_BITS))
        begin
            guess = 64'd1 << Q_FRAC_BITS;
        end
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            divisor = (guess != 64'd0) ? guess : 64'd1;
            quot    = (x << Q_FRAC_BITS) / divisor;
            guess   = (guess + quot) >> 1;
        end
        return guess[ROOT_W-1:0];
    endfunction

    function automatic logic [OPERAND_W-1:0] pick_operand();
        int                   sel;
        int                   k;
        logic [OPERAND_W-1:0] value;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            value = $urandom;
        end
        else if (sel < 35)
        begin
            value = $urandom;
            value[OPERAND_W-1] = 1'b1;
        end
        else if (sel < 45)
        begin
            value = $urandom_range(1, 65535);
        end
        else if (sel < 58)
        begin
            k     = $urandom_range(1, 181);
            value = (k * k) << Q_FRAC_BITS;
            value = value + $urandom_range(0, 8) - 4;
        end
        else if (sel < 65)
        begin
            k     = $urandom_range(1, 46340);
            value = k * k;
        end
        else if (sel < 67)
        begin
            value = '0;
        end
        else
        begin
            value = $urandom;
            value[OPERAND_W-1] = 1'b0;
            value = value >> $urandom_range(0, 30);
            if (value == '0)
            begin
                value = 32'd1;
            end
        end
        return value;
    endfunction

    task automatic send_item(input logic [OPERAND_W-1:0] value);
        root_item_t item;
        start   <= 1'b1;
        operand <= value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        item.operand = value;
        item.root    = sqrt_q16(value);
        pending_roots.push_back(item);
        items_sent++;
        if (!value[OPERAND_W-1] && value != '0)
        begin
            positive_items++;
        end
    endtask

    task automatic idle_gap();
        int sel;
        int cycles;
        sel = $urandom_range(0, 99);
        if (!idle_enabled || sel < 45)
        begin
            cycles = 0;
        end
        else if (sel < 85)
        begin
            cycles = $urandom_range(1, 4);
        end
        else if (sel < 97)
        begin
            cycles = $urandom_range(5, 40);
        end
        else
        begin
            cycles = $urandom_range(41, 320);
        end
        if (cycles > 0)
        begin
            start   <= 1'b0;
            operand <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_roots.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_boundary_values();
        logic [OPERAND_W-1:0] values[$];
        values = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
                   32'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFE_FFFF, 32'h4000_0000,
                   32'h0000_0001, 32'h0000_0002, 32'h0000_0100, 32'h0000_8000,
                   32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h0002_0000,
                   32'h0004_0000, 32'h0009_0000, 32'h00FF_FFFF, 32'h5555_5555,
                   32'h2AAA_AAAA};
        foreach (values[i])
        begin
            send_item(values[i]);
            idle_gap();
        end
    endtask

    task automatic test_nonpositive_burst(input int count);
        logic [OPERAND_W-1:0] value;
        for (int i = 0; i < count; i++)
        begin
            value = $urandom;
            value[OPERAND_W-1] = ($urandom_range(0, 7) != 0);
            if (!value[OPERAND_W-1])
            begin
                value = '0;
            end
            send_item(value);
        end
    endtask

    task automatic test_drain_pause(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_item(pick_operand());
            if (i % 5 == 4)
            begin
                wait_for_drain();
            end
            else
            begin
                idle_gap();
            end
        end
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                idle_enabled = ($urandom_range(0, 3) != 0);
            end
            send_item(pick_operand());
            idle_gap();
        end
        idle_enabled = 1'b1;
    endtask

    always @(posedge clk)
    begin : check_roots
        root_item_t want;
        if (done === 1'b1)
        begin
            if (pending_roots.size() == 0)
            begin
                $error("root: expected none, actual %h", root);
                fail_count++;
            end
            else
            begin
                want = pending_roots.pop_front();
                roots_checked++;
                if (root !== want.root)
                begin
                    $error("root: expected %h, actual %h (operand %h)",
                           want.root, root, want.operand);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("[fixed_point_newton_sqrt] ERROR");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        operand        = '0;
        items_sent     = 0;
        positive_items = 0;
        roots_checked  = 0;
        fail_count     = 0;
        idle_enabled   = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boundary_values();
        test_nonpositive_burst(30);
        test_drain_pause(20);
        test_random_mix(1780);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items, %0d of them positive and %0d zero or negative.",
                 items_sent, positive_items, items_sent - positive_items);
        $display("Compared %0d roots, with %0d mismatches or stray results.",
                 roots_checked, fail_count);
        if (fail_count == 0 && pending_roots.size() == 0)
        begin
            $display("[fixed_point_newton_sqrt] OK");
        end
        else
        begin
            $display("[fixed_point_newton_sqrt] ERROR");
        end
        $finish;
    end

endmodule

// ===== fixed_point_newton_sqrt.f =====
design/fpns_pkg.sv
design/fpns_isqrt.sv
design/fpns_div.sv
design/fixed_point_newton_sqrt.sv
dv/tb_top.sv
